// ===== design/sbrbp_pkg.sv =====
// sbrbp_pkg: shared types and constants for the banked register and buffer port.
// No dependencies; every other file in design/ refers to it by scoped names.
package sbrbp_pkg;

    localparam int BUFFER_DEPTH_DEF = 8192;
    localparam int BANK_COUNT_DEF   = 4;

    localparam int OPCODE_W = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 8;
    localparam int PTR_W    = 13;

    // bank 0 / common register addresses
    localparam logic [ADDR_W-1:0] A_RDPT_L  = 5'h00;
    localparam logic [ADDR_W-1:0] A_RDPT_H  = 5'h01;
    localparam logic [ADDR_W-1:0] A_WRPT_L  = 5'h02;
    localparam logic [ADDR_W-1:0] A_WRPT_H  = 5'h03;
    localparam logic [ADDR_W-1:0] A_RXST_L  = 5'h08;
    localparam logic [ADDR_W-1:0] A_RXST_H  = 5'h09;
    localparam logic [ADDR_W-1:0] A_RXND_L  = 5'h0A;
    localparam logic [ADDR_W-1:0] A_RXND_H  = 5'h0B;
    localparam logic [ADDR_W-1:0] A_COMMON  = 5'h1B;
    localparam logic [ADDR_W-1:0] A_ECON2   = 5'h1E;
    localparam logic [ADDR_W-1:0] A_ECON1   = 5'h1F;

    localparam logic [DATA_W-1:0] ECON2_RST   = 8'h80;
    localparam logic [PTR_W-1:0]  RDPT_RST    = 13'h05FA;
    localparam int                AUTOINC_BIT = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RD_REG  = 3'd0,
        OP_WR_REG  = 3'd1,
        OP_BIT_SET = 3'd2,
        OP_BIT_CLR = 3'd3,
        OP_RD_BUF  = 3'd4,
        OP_WR_BUF  = 3'd5,
        OP_SOFT_RST = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_ACCESS,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the accepted word
        logic addr;    // resolve register index and buffer address
        logic access;  // read/modify/write registers and buffer
        logic result;  // load the output register
    } t_dp_cmd;

endpackage

// ===== design/sbrbp_if.sv =====
// Handshake interfaces for the command and response channels.
// Depends on sbrbp_pkg for field widths.
interface sbrbp_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [sbrbp_pkg::OPCODE_W-1:0]    opcode;
    logic [sbrbp_pkg::ADDR_W-1:0]      reg_addr;
    logic [sbrbp_pkg::DATA_W-1:0]      write_data;

    modport source (output valid, output opcode, output reg_addr, output write_data,
                    input ready);
    modport sink (input valid, input opcode, input reg_addr, input write_data,
                  output ready);
endinterface

interface sbrbp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sbrbp_pkg::DATA_W-1:0]  read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

// ===== design/sbrbp_ctrl.sv =====
// sbrbp_ctrl: command sequencer and handshake control.
// Depends on sbrbp_pkg (t_state, t_dp_cmd).
module sbrbp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sbrbp_pkg::t_dp_cmd o_cmd
);

    sbrbp_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbrbp_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sbrbp_pkg::ST_ADDR;
            end
            sbrbp_pkg::ST_ADDR:   n_state = sbrbp_pkg::ST_ACCESS;
            sbrbp_pkg::ST_ACCESS: n_state = sbrbp_pkg::ST_DONE;
            sbrbp_pkg::ST_DONE: begin
                if (out_free) n_state = sbrbp_pkg::ST_IDLE;
            end
            default: n_state = sbrbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            sbrbp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sbrbp_pkg::ST_ADDR:   o_cmd.addr   = 1'b1;
            sbrbp_pkg::ST_ACCESS: o_cmd.access = 1'b1;
            sbrbp_pkg::ST_DONE:   o_cmd.result = out_free;
            default: begin
                o_in_ready = 1'b0;
                o_cmd      = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.result)    n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbrbp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/sbrbp_datapath.sv =====
// sbrbp_datapath: banked register file, pointer registers and buffer memory.
// Depends on sbrbp_pkg; driven by sbrbp_ctrl through t_dp_cmd.
module sbrbp_datapath #(
    parameter int BUFFER_DEPTH = sbrbp_pkg::BUFFER_DEPTH_DEF,
    parameter int BANK_COUNT   = sbrbp_pkg::BANK_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sbrbp_pkg::t_dp_cmd               i_cmd,
    input  logic [sbrbp_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [sbrbp_pkg::ADDR_W-1:0]     i_reg_addr,
    input  logic [sbrbp_pkg::DATA_W-1:0]     i_write_data,
    output logic [sbrbp_pkg::DATA_W-1:0]     o_read_data
);

    localparam int DW        = sbrbp_pkg::DATA_W;
    localparam int AW        = sbrbp_pkg::ADDR_W;
    localparam int PW        = sbrbp_pkg::PTR_W;
    localparam int REG_DEPTH = BANK_COUNT * 32;
    localparam int IDX_W     = $clog2(REG_DEPTH);
    localparam int BA_W      = $clog2(BUFFER_DEPTH);
    // subtract steps needed to bring a 13-bit pointer below BUFFER_DEPTH
    localparam int MOD_STEPS = $clog2(((2 ** PW) + BUFFER_DEPTH - 1) / BUFFER_DEPTH);

    // captured word
    sbrbp_pkg::t_opcode r_opcode;
    logic [AW-1:0]      r_addr;
    logic [DW-1:0]      r_data;

    // registers held in flops: pointer pairs and the two control registers
    logic [DW-1:0] r_rdpt_l, r_rdpt_h, r_wrpt_l, r_wrpt_h;
    logic [DW-1:0] r_rxst_l, r_rxst_h, r_rxnd_l, r_rxnd_h;
    logic [DW-1:0] r_econ2, r_econ1;
    logic [DW-1:0] n_rdpt_l, n_rdpt_h, n_wrpt_l, n_wrpt_h;
    logic [DW-1:0] n_rxst_l, n_rxst_h, n_rxnd_l, n_rxnd_h;
    logic [DW-1:0] n_econ2, n_econ1;

    // remaining register bytes: memory plus per-entry valid bits (invalid reads zero)
    logic [DW-1:0]        reg_mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] r_vld, n_vld;
    logic [DW-1:0]        r_reg_q;
    logic [IDX_W-1:0]     r_ridx;

    logic [DW-1:0]   buf_mem [BUFFER_DEPTH];
    logic [DW-1:0]   r_buf_q;
    logic [BA_W-1:0] r_baddr;

    logic [DW-1:0] r_result;
    logic [DW-1:0] r_rd_data;

    // address stage
    logic [1:0]       bank;
    logic [6:0]       bank_raw;
    logic [IDX_W-1:0] idx_calc;
    logic [PW-1:0]    rd_ptr, wr_ptr, rxst_ptr, rxnd_ptr, sel_ptr, rem;
    logic [BA_W-1:0]  baddr_calc;

    // access stage
    logic [AW-1:0] lo;
    logic          bank0, is_ded;
    logic [DW-1:0] ded_val, cur_val, wval;
    logic [PW-1:0] rd_next, wr_next;
    logic          mem_we, buf_we, autoinc;

    assign rd_ptr   = {r_rdpt_h[PW-DW-1:0], r_rdpt_l};
    assign wr_ptr   = {r_wrpt_h[PW-DW-1:0], r_wrpt_l};
    assign rxst_ptr = {r_rxst_h[PW-DW-1:0], r_rxst_l};
    assign rxnd_ptr = {r_rxnd_h[PW-DW-1:0], r_rxnd_l};
    assign autoinc  = r_econ2[sbrbp_pkg::AUTOINC_BIT];

    // bank = (ECON1 & 3) mod BANK_COUNT; value < 4 so one conditional subtract
    always_comb begin
        bank = r_econ1[1:0];
        if (int'(r_econ1[1:0]) >= BANK_COUNT) bank = 2'(int'(r_econ1[1:0]) - BANK_COUNT);
        bank_raw = {bank, r_addr};
        if (r_addr >= sbrbp_pkg::A_COMMON) idx_calc = IDX_W'(r_addr);
        else                               idx_calc = IDX_W'(bank_raw);
    end

    // pointer modulo buffer depth: restoring subtract of depth multiples
    always_comb begin
        sel_ptr = (r_opcode == sbrbp_pkg::OP_WR_BUF) ? wr_ptr : rd_ptr;
        rem     = sel_ptr;
        for (int i = MOD_STEPS - 1; i >= 0; i--) begin
            if (int'(rem) >= (BUFFER_DEPTH << i)) rem = rem - PW'(BUFFER_DEPTH << i);
        end
        baddr_calc = BA_W'(rem);
    end

    // dedicated register decode
    assign lo    = r_ridx[AW-1:0];
    assign bank0 = (r_ridx >> AW) == '0;

    always_comb begin
        is_ded  = bank0;
        ded_val = '0;
        case (lo)
            sbrbp_pkg::A_RDPT_L: ded_val = r_rdpt_l;
            sbrbp_pkg::A_RDPT_H: ded_val = r_rdpt_h;
            sbrbp_pkg::A_WRPT_L: ded_val = r_wrpt_l;
            sbrbp_pkg::A_WRPT_H: ded_val = r_wrpt_h;
            sbrbp_pkg::A_RXST_L: ded_val = r_rxst_l;
            sbrbp_pkg::A_RXST_H: ded_val = r_rxst_h;
            sbrbp_pkg::A_RXND_L: ded_val = r_rxnd_l;
            sbrbp_pkg::A_RXND_H: ded_val = r_rxnd_h;
            sbrbp_pkg::A_ECON2:  ded_val = r_econ2;
            sbrbp_pkg::A_ECON1:  ded_val = r_econ1;
            default:             is_ded  = 1'b0;
        endcase
    end

    always_comb begin
        if (is_ded)             cur_val = ded_val;
        else if (r_vld[r_ridx]) cur_val = r_reg_q;
        else                    cur_val = '0;
        case (r_opcode)
            sbrbp_pkg::OP_BIT_SET: wval = cur_val | r_data;
            sbrbp_pkg::OP_BIT_CLR: wval = cur_val & ~r_data;
            default:               wval = r_data;
        endcase
    end

    assign rd_next = (rd_ptr == rxnd_ptr) ? rxst_ptr : rd_ptr + PW'(1);
    assign wr_next = wr_ptr + PW'(1);

    always_comb begin
        n_rdpt_l = r_rdpt_l; n_rdpt_h = r_rdpt_h;
        n_wrpt_l = r_wrpt_l; n_wrpt_h = r_wrpt_h;
        n_rxst_l = r_rxst_l; n_rxst_h = r_rxst_h;
        n_rxnd_l = r_rxnd_l; n_rxnd_h = r_rxnd_h;
        n_econ2  = r_econ2;  n_econ1  = r_econ1;
        n_vld    = r_vld;
        mem_we   = 1'b0;
        buf_we   = 1'b0;
        if (i_cmd.access) begin
            case (r_opcode)
                sbrbp_pkg::OP_WR_REG, sbrbp_pkg::OP_BIT_SET, sbrbp_pkg::OP_BIT_CLR: begin
                    if (is_ded) begin
                        case (lo)
                            sbrbp_pkg::A_RDPT_L: n_rdpt_l = wval;
                            sbrbp_pkg::A_RDPT_H: n_rdpt_h = wval;
                            sbrbp_pkg::A_WRPT_L: n_wrpt_l = wval;
                            sbrbp_pkg::A_WRPT_H: n_wrpt_h = wval;
                            sbrbp_pkg::A_RXST_L: n_rxst_l = wval;
                            sbrbp_pkg::A_RXST_H: n_rxst_h = wval;
                            sbrbp_pkg::A_RXND_L: n_rxnd_l = wval;
                            sbrbp_pkg::A_RXND_H: n_rxnd_h = wval;
                            sbrbp_pkg::A_ECON2:  n_econ2  = wval;
                            sbrbp_pkg::A_ECON1:  n_econ1  = wval;
                            default:             n_econ1  = r_econ1;
                        endcase
                    end else begin
                        mem_we        = 1'b1;
                        n_vld[r_ridx] = 1'b1;
                    end
                end
                sbrbp_pkg::OP_RD_BUF: begin
                    if (autoinc) begin
                        n_rdpt_l = rd_next[DW-1:0];
                        n_rdpt_h = DW'(rd_next[PW-1:DW]);
                    end
                end
                sbrbp_pkg::OP_WR_BUF: begin
                    buf_we = 1'b1;
                    if (autoinc) begin
                        n_wrpt_l = wr_next[DW-1:0];
                        n_wrpt_h = DW'(wr_next[PW-1:DW]);
                    end
                end
                sbrbp_pkg::OP_SOFT_RST: begin
                    n_rdpt_l = sbrbp_pkg::RDPT_RST[DW-1:0];
                    n_rdpt_h = DW'(sbrbp_pkg::RDPT_RST[PW-1:DW]);
                    n_wrpt_l = '0; n_wrpt_h = '0;
                    n_rxst_l = '0; n_rxst_h = '0;
                    n_rxnd_l = '0; n_rxnd_h = '0;
                    n_econ2  = sbrbp_pkg::ECON2_RST;
                    n_econ1  = '0;
                    n_vld    = '0;
                end
                default: n_vld = r_vld;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdpt_l <= sbrbp_pkg::RDPT_RST[DW-1:0];
            r_rdpt_h <= DW'(sbrbp_pkg::RDPT_RST[PW-1:DW]);
            r_wrpt_l <= '0; r_wrpt_h <= '0;
            r_rxst_l <= '0; r_rxst_h <= '0;
            r_rxnd_l <= '0; r_rxnd_h <= '0;
            r_econ2  <= sbrbp_pkg::ECON2_RST;
            r_econ1  <= '0;
            r_vld    <= '0;
        end else begin
            r_rdpt_l <= n_rdpt_l; r_rdpt_h <= n_rdpt_h;
            r_wrpt_l <= n_wrpt_l; r_wrpt_h <= n_wrpt_h;
            r_rxst_l <= n_rxst_l; r_rxst_h <= n_rxst_h;
            r_rxnd_l <= n_rxnd_l; r_rxnd_h <= n_rxnd_h;
            r_econ2  <= n_econ2;  r_econ1  <= n_econ1;
            r_vld    <= n_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= sbrbp_pkg::t_opcode'(i_opcode);
            r_addr   <= i_reg_addr;
            r_data   <= i_write_data;
        end
        if (i_cmd.addr) begin
            r_ridx  <= idx_calc;
            r_baddr <= baddr_calc;
        end
        if (i_cmd.access) begin
            r_result <= (r_opcode == sbrbp_pkg::OP_RD_REG) ? cur_val : '0;
        end
        if (i_cmd.result) begin
            r_rd_data <= (r_opcode == sbrbp_pkg::OP_RD_BUF) ? r_buf_q : r_result;
        end
    end

    // register memory: read in the address cycle, written in the access cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) reg_mem[r_ridx] <= wval;
        if (i_cmd.addr) r_reg_q <= reg_mem[idx_calc];
    end

    // buffer memory: one access in the access cycle
    always_ff @(posedge i_clk) begin
        if (buf_we) buf_mem[r_baddr] <= r_data;
        if (i_cmd.access) r_buf_q <= buf_mem[r_baddr];
    end

    assign o_read_data = r_rd_data;

endmodule

// ===== design/spi_banked_register_and_buffer_port.sv =====
// spi_banked_register_and_buffer_port: top level of the banked register and buffer port.
// Depends on sbrbp_pkg, sbrbp_if.sv, sbrbp_ctrl and sbrbp_datapath.
//
//   Channel   Dir   Handshake           Word contents
//   i_cmd     in    valid/ready         opcode[2:0], reg_addr[4:0], write_data[7:0]
//   o_rsp     out   valid/ready         read_data[7:0]
//
// Sequence: a word passes accept, address resolve, access and result, in the order
//   set by the controller's sequence through the register and buffer memory ports.
// Reset: i_rst_n synchronous, active low; registers return to their reset values
//   at once through per-entry valid bits, the buffer memory is not cleared.
// Stalls: a result waits in the output register while o_rsp.ready is low; the
//   controller still takes one more word, carries it to its result state and
//   holds there, taking no further word until the output register is free.
module spi_banked_register_and_buffer_port #(
    parameter int BUFFER_DEPTH = sbrbp_pkg::BUFFER_DEPTH_DEF,
    parameter int BANK_COUNT   = sbrbp_pkg::BANK_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbrbp_cmd_if.sink    i_cmd,
    sbrbp_rsp_if.source  o_rsp
);

    // controller -> datapath commands
    sbrbp_pkg::t_dp_cmd dp_cmd;

    // sequencer: owns both handshakes
    sbrbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd)
    );

    // register file, pointers, buffer memory and output register
    sbrbp_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .BANK_COUNT   (BANK_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_opcode     (i_cmd.opcode),
        .i_reg_addr   (i_cmd.reg_addr),
        .i_write_data (i_cmd.write_data),
        .o_read_data  (o_rsp.read_data)
    );

endmodule
